// ===== rtl/spdm_pkg.sv =====
// ----------------------------------------------------------------------------
// spdm_pkg
// Shared types and constants for the stereo pair downmixer: beat structs,
// configuration register indexes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package spdm_pkg;

  // Sample width is fixed by the beat formats
  localparam int SAMPLE_BITS = 16;

  // Defaults for the top level parameters
  localparam int MAX_FRAMES_DEF   = 1024;
  localparam int MAX_CHANNELS_DEF = 8;

  // Divider: quotient bits resolved per cycle
  localparam int DIV_STEP = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_B   = 2'd2;

  // Input beat: one interleaved channel sample
  typedef struct packed {
    logic                          source;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_block;
  } in_beat_t;

  // Output beat: one stereo frame
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/stereo_pair_downmixer.sv =====
// ----------------------------------------------------------------------------
// stereo_pair_downmixer
// Averages interleaved A/B source blocks to mono and either duplicates each
// mono frame to both channels or pairs an A block with a B block into stereo.
// ----------------------------------------------------------------------------
// One sample is handled at a time. A sample that does not complete a frame
// is accepted and then finished. A sample that completes a frame also runs
// the mono average through a restoring divider that resolves DIV_STEP
// quotient bits per cycle between its accept and finish cycles. The finish
// cycle waits while the output register holds a beat that is stalled. The
// pending block lives in a MAX_FRAMES-deep synchronous memory that is read
// at the current frame index while the divider runs and written in the
// finish cycle; it needs no clearing pass, since only entries below the
// stored block length are read. Configuration is always ready and must be
// written only while no sample is in flight.
`default_nettype none

module stereo_pair_downmixer #(
  parameter int MAX_FRAMES   = spdm_pkg::MAX_FRAMES_DEF,
  parameter int MAX_CHANNELS = spdm_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // sample input
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire spdm_pkg::in_beat_t                 in_data,
  // stereo output
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output spdm_pkg::out_beat_t                     out_data,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [spdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spdm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SB      = spdm_pkg::SAMPLE_BITS;
  localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W   = SB + $clog2(MAX_CHANNELS);
  localparam int DIV_CYC = (SUM_W + spdm_pkg::DIV_STEP - 1) / spdm_pkg::DIV_STEP;
  localparam int DIV_W   = DIV_CYC * spdm_pkg::DIV_STEP;
  localparam int ITER_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int FI_W    = $clog2(MAX_FRAMES + 1);
  localparam int AW      = $clog2(MAX_FRAMES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Configuration registers
  logic                              pair_r,   pair_nxt;
  logic [spdm_pkg::CFG_DATA_W-1:0]   chan_a_r, chan_a_nxt;
  logic [spdm_pkg::CFG_DATA_W-1:0]   chan_b_r, chan_b_nxt;

  // Control state
  logic [1:0]              state_r,      state_nxt;
  logic signed [SUM_W-1:0] sum_r,        sum_nxt;
  logic [CH_W-1:0]         cnt_r,        cnt_nxt;
  logic [FI_W-1:0]         fidx_r,       fidx_nxt;
  logic                    bhf_r,        bhf_nxt;
  logic [FI_W-1:0]         pend_len_r,   pend_len_nxt;
  logic                    pend_src_r,   pend_src_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [ITER_W-1:0]       iter_r,       iter_nxt;
  logic                    out_valid_r,  out_valid_nxt;

  // Per-sample working registers
  logic                    src_r,   src_nxt;
  logic                    last_r,  last_nxt;
  logic                    frame_r, frame_nxt;
  logic                    neg_r,   neg_nxt;
  logic [DIV_W-1:0]        num_r,   num_nxt;
  logic [CH_W-1:0]         rem_r,   rem_nxt;
  logic [CH_W-1:0]         div_r,   div_nxt;
  spdm_pkg::out_beat_t     out_data_r, out_data_nxt;

  // Pending block memory
  logic [SB-1:0]           pend_mem [MAX_FRAMES];
  logic [SB-1:0]           rd_data_r;
  logic                    mem_we;

  // Datapath nets
  logic                    in_accept;
  logic                    out_free;
  logic [CH_W-1:0]         nch;
  logic signed [SUM_W-1:0] sum_new;
  logic [CH_W-1:0]         cnt_new;
  logic [SUM_W-1:0]        mag;
  logic [DIV_W-1:0]        div_num;
  logic [CH_W-1:0]         div_rem;
  logic [SB-1:0]           quo;
  logic [SB-1:0]           mono;
  logic                    fits;

  // Channel count clamped to 1..MAX_CHANNELS
  function automatic logic [CH_W-1:0] clamp_ch(input logic [spdm_pkg::CFG_DATA_W-1:0] c);
    logic [CH_W-1:0] r;
    if (c == '0) begin
      r = CH_W'(1);
    end else if (32'(c) > MAX_CHANNELS) begin
      r = CH_W'(MAX_CHANNELS);
    end else begin
      r = CH_W'(c);
    end
    return r;
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Frame accumulation
  assign nch     = clamp_ch(in_data.source ? chan_b_r : chan_a_r);
  assign sum_new = sum_r + SUM_W'(in_data.sample);
  assign cnt_new = cnt_r + 1'b1;
  assign mag     = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  // Restoring divider: DIV_STEP quotient bits per cycle
  always_comb begin
    logic [CH_W:0]    sh;
    logic [CH_W-1:0]  rem;
    logic [DIV_W-1:0] num;
    rem = rem_r;
    num = num_r;
    for (int k = 0; k < spdm_pkg::DIV_STEP; k++) begin
      sh  = {rem, num[DIV_W-1]};
      num = {num[DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, div_r}) begin
        rem    = CH_W'(sh - {1'b0, div_r});
        num[0] = 1'b1;
      end else begin
        rem = sh[CH_W-1:0];
      end
    end
    div_num = num;
    div_rem = rem;
  end

  // Signed mono, truncated toward zero
  assign quo  = num_r[SB-1:0];
  assign mono = neg_r ? SB'(-quo) : quo;
  assign fits = (fidx_r < FI_W'(MAX_FRAMES));

  // Next-state logic
  always_comb begin
    logic [FI_W-1:0] fidx_upd;
    logic            bhf_upd;
    pair_nxt       = pair_r;
    chan_a_nxt     = chan_a_r;
    chan_b_nxt     = chan_b_r;
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    fidx_nxt       = fidx_r;
    bhf_nxt        = bhf_r;
    pend_len_nxt   = pend_len_r;
    pend_src_nxt   = pend_src_r;
    pend_valid_nxt = pend_valid_r;
    iter_nxt       = iter_r;
    src_nxt        = src_r;
    last_nxt       = last_r;
    frame_nxt      = frame_r;
    neg_nxt        = neg_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    fidx_upd       = fidx_r;
    bhf_upd        = bhf_r;

    // register writes
    if (cfg_valid) begin
      case (cfg_index)
        spdm_pkg::CFG_PAIR_ENABLED: pair_nxt   = cfg_data[0];
        spdm_pkg::CFG_CHANNELS_A:   chan_a_nxt = cfg_data;
        spdm_pkg::CFG_CHANNELS_B:   chan_b_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          src_nxt  = in_data.source;
          last_nxt = in_data.last_in_block;
          if (cnt_new >= nch) begin
            // frame complete: start the average
            frame_nxt = 1'b1;
            sum_nxt   = '0;
            cnt_nxt   = '0;
            neg_nxt   = sum_new[SUM_W-1];
            num_nxt   = DIV_W'(mag);
            rem_nxt   = '0;
            div_nxt   = nch;
            iter_nxt  = ITER_W'(DIV_CYC - 1);
            state_nxt = ST_DIV;
          end else begin
            frame_nxt = 1'b0;
            sum_nxt   = sum_new;
            cnt_nxt   = cnt_new;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        num_nxt  = div_num;
        rem_nxt  = div_rem;
        iter_nxt = ITER_W'(iter_r - 1'b1);
        if (iter_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          bhf_upd = bhf_r || frame_r;
          // route the mono frame
          if (frame_r && fits) begin
            if (!pair_r) begin
              out_valid_nxt             = 1'b1;
              out_data_nxt.left_sample  = mono;
              out_data_nxt.right_sample = mono;
            end else if (pend_valid_r && (pend_src_r != src_r)) begin
              if (fidx_r < pend_len_r) begin
                out_valid_nxt             = 1'b1;
                out_data_nxt.left_sample  = src_r ? rd_data_r : mono;
                out_data_nxt.right_sample = src_r ? mono : rd_data_r;
              end
            end else begin
              mem_we = 1'b1;
            end
            fidx_upd = fidx_r + 1'b1;
          end
          fidx_nxt = fidx_upd;
          bhf_nxt  = bhf_upd;
          // block end: store or retire the pending block
          if (last_r) begin
            if (bhf_upd && pair_r) begin
              if (pend_valid_r && (pend_src_r != src_r)) begin
                pend_valid_nxt = 1'b0;
              end else begin
                pend_valid_nxt = 1'b1;
                pend_src_nxt   = src_r;
                pend_len_nxt   = fidx_upd;
              end
            end
            sum_nxt  = '0;
            cnt_nxt  = '0;
            fidx_nxt = '0;
            bhf_nxt  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r       <= 1'b0;
      chan_a_r     <= spdm_pkg::CFG_DATA_W'(1);
      chan_b_r     <= spdm_pkg::CFG_DATA_W'(1);
      state_r      <= ST_IDLE;
      sum_r        <= '0;
      cnt_r        <= '0;
      fidx_r       <= '0;
      bhf_r        <= 1'b0;
      pend_len_r   <= '0;
      pend_src_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      iter_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pair_r       <= pair_nxt;
      chan_a_r     <= chan_a_nxt;
      chan_b_r     <= chan_b_nxt;
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      fidx_r       <= fidx_nxt;
      bhf_r        <= bhf_nxt;
      pend_len_r   <= pend_len_nxt;
      pend_src_r   <= pend_src_nxt;
      pend_valid_r <= pend_valid_nxt;
      iter_r       <= iter_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    last_r     <= last_nxt;
    frame_r    <= frame_nxt;
    neg_r      <= neg_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    out_data_r <= out_data_nxt;
  end

  // Pending block memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pend_mem[fidx_r[AW-1:0]] <= mono;
    end
    rd_data_r <= pend_mem[fidx_r[AW-1:0]];
  end

endmodule

`default_nettype wire

// ===== rtl/spdm_checker.sv =====
// ----------------------------------------------------------------------------
// spdm_checker
// Port-level assertions for the stereo pair downmixer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module spdm_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire spdm_pkg::out_beat_t             out_data,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [spdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [spdm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Shadow of the pairing mode, tracked from config beats
  logic pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= 1'b0;
    end else if (cfg_valid && cfg_ready && (cfg_index == spdm_pkg::CFG_PAIR_ENABLED)) begin
      pair_r <= cfg_data[0];
    end
  end

  // A stalled output beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // One sample in flight: input stalls right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a sample is in flight");

  // Without pairing, every frame leaves as identical left and right
  a_dup_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pair_r |-> out_data.left_sample == out_data.right_sample)
    else $error("duplicated frame has differing channels");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat valid after reset");

endmodule

bind stereo_pair_downmixer spdm_checker u_spdm_checker (.*);

`default_nettype wire
